@@ sv/mtp_pkg.sv @@
// mtp_pkg: shared types, character codes and lookup tables for the note parser.
// No dependencies; used by mtp_ctrl, mtp_datapath and music_note_to_tone_parser.
`default_nettype none

package mtp_pkg;

    localparam int WHOLE_W   = 20;  // whole note length register
    localparam int DIVISOR_W = 16;  // duration divisor
    localparam int DUR_W     = 21;  // duration result
    localparam int FREQ_W    = 14;  // frequency result
    localparam int IDX_W     = 7;   // tone ROM index, 110 entries
    localparam int POS_W     = 4;   // saturating character count
    localparam int DIV_STEPS = WHOLE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_FLAT  = 8'h62;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam logic [POS_W-1:0]     POS_MAX      = 4'd15;
    localparam logic [3:0]           OCTAVE_MAX   = 4'd8;
    localparam logic [IDX_W-1:0]     IDX_MAX      = 7'd109;
    localparam logic [DIVISOR_W-1:0] DIVISOR_SAT  = 16'hFFFF;
    localparam logic [WHOLE_W-1:0]   WHOLE_RESET  = 20'd2000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_NOTE = 2'd1,
        ST_NO_DIV   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACC_NATURAL = 2'd0,
        ACC_SHARP   = 2'd1,
        ACC_FLAT    = 2'd2
    } t_accid;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // input request taken this cycle
        logic step;      // one restoring-division step
        logic load_out;  // move finished result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_full;
    } t_sts;

    // half steps above C for letters A..G
    function automatic logic [3:0] letter_semis(input logic [2:0] l);
        logic [3:0] s;
        case (l)
            3'd0: s = 4'd9;
            3'd1: s = 4'd11;
            3'd2: s = 4'd0;
            3'd3: s = 4'd2;
            3'd4: s = 4'd4;
            3'd5: s = 4'd5;
            3'd6: s = 4'd7;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // rounded 440*2^(n/12), index 0 = B-1 .. 109 = C9
    function automatic logic [FREQ_W-1:0] tone_rom(input logic [IDX_W-1:0] i);
        logic [FREQ_W-1:0] f;
        case (i)
            7'd0: f = 14'd15;
            7'd1: f = 14'd16;    7'd2: f = 14'd17;    7'd3: f = 14'd18;
            7'd4: f = 14'd19;    7'd5: f = 14'd21;    7'd6: f = 14'd22;
            7'd7: f = 14'd23;    7'd8: f = 14'd24;    7'd9: f = 14'd26;
            7'd10: f = 14'd28;   7'd11: f = 14'd29;   7'd12: f = 14'd31;
            7'd13: f = 14'd33;   7'd14: f = 14'd35;   7'd15: f = 14'd37;
            7'd16: f = 14'd39;   7'd17: f = 14'd41;   7'd18: f = 14'd44;
            7'd19: f = 14'd46;   7'd20: f = 14'd49;   7'd21: f = 14'd52;
            7'd22: f = 14'd55;   7'd23: f = 14'd58;   7'd24: f = 14'd62;
            7'd25: f = 14'd65;   7'd26: f = 14'd69;   7'd27: f = 14'd73;
            7'd28: f = 14'd78;   7'd29: f = 14'd82;   7'd30: f = 14'd87;
            7'd31: f = 14'd92;   7'd32: f = 14'd98;   7'd33: f = 14'd104;
            7'd34: f = 14'd110;  7'd35: f = 14'd117;  7'd36: f = 14'd123;
            7'd37: f = 14'd131;  7'd38: f = 14'd139;  7'd39: f = 14'd147;
            7'd40: f = 14'd156;  7'd41: f = 14'd165;  7'd42: f = 14'd175;
            7'd43: f = 14'd185;  7'd44: f = 14'd196;  7'd45: f = 14'd208;
            7'd46: f = 14'd220;  7'd47: f = 14'd233;  7'd48: f = 14'd247;
            7'd49: f = 14'd262;  7'd50: f = 14'd277;  7'd51: f = 14'd294;
            7'd52: f = 14'd311;  7'd53: f = 14'd330;  7'd54: f = 14'd349;
            7'd55: f = 14'd370;  7'd56: f = 14'd392;  7'd57: f = 14'd415;
            7'd58: f = 14'd440;  7'd59: f = 14'd466;  7'd60: f = 14'd494;
            7'd61: f = 14'd523;  7'd62: f = 14'd554;  7'd63: f = 14'd587;
            7'd64: f = 14'd622;  7'd65: f = 14'd659;  7'd66: f = 14'd698;
            7'd67: f = 14'd740;  7'd68: f = 14'd784;  7'd69: f = 14'd831;
            7'd70: f = 14'd880;  7'd71: f = 14'd932;  7'd72: f = 14'd988;
            7'd73: f = 14'd1047; 7'd74: f = 14'd1109; 7'd75: f = 14'd1175;
            7'd76: f = 14'd1245; 7'd77: f = 14'd1319; 7'd78: f = 14'd1397;
            7'd79: f = 14'd1480; 7'd80: f = 14'd1568; 7'd81: f = 14'd1661;
            7'd82: f = 14'd1760; 7'd83: f = 14'd1865; 7'd84: f = 14'd1976;
            7'd85: f = 14'd2093; 7'd86: f = 14'd2217; 7'd87: f = 14'd2349;
            7'd88: f = 14'd2489; 7'd89: f = 14'd2637; 7'd90: f = 14'd2794;
            7'd91: f = 14'd2960; 7'd92: f = 14'd3136; 7'd93: f = 14'd3322;
            7'd94: f = 14'd3520; 7'd95: f = 14'd3729; 7'd96: f = 14'd3951;
            7'd97: f = 14'd4186; 7'd98: f = 14'd4435; 7'd99: f = 14'd4699;
            7'd100: f = 14'd4978; 7'd101: f = 14'd5274; 7'd102: f = 14'd5588;
            7'd103: f = 14'd5920; 7'd104: f = 14'd6272; 7'd105: f = 14'd6645;
            7'd106: f = 14'd7040; 7'd107: f = 14'd7459; 7'd108: f = 14'd7902;
            7'd109: f = 14'd8372;
            default: f = 14'd8372;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

@@ sv/mtp_ctrl.sv @@
// mtp_ctrl: sequencer for the note parser (idle / divide / finish).
// Depends on mtp_pkg for the state, command and status types.
`default_nettype none

module mtp_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_last,
    output logic               o_in_ready,
    input  wire                i_out_ready,
    input  wire mtp_pkg::t_sts i_sts,
    output mtp_pkg::t_cmd      o_cmd
);

    mtp_pkg::t_state               r_state, n_state;
    logic [mtp_pkg::STEP_W-1:0]    r_step, n_step;
    logic                          w_accept;
    logic                          w_out_free;

    assign o_in_ready = (r_state == mtp_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !i_sts.out_full || i_out_ready;

    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        o_cmd.accept    = w_accept;
        o_cmd.step      = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            mtp_pkg::S_IDLE: begin
                if (w_accept && i_in_last) begin
                    n_state = mtp_pkg::S_DIV;
                    n_step  = '0;
                end
            end
            mtp_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == mtp_pkg::STEP_W'(mtp_pkg::DIV_STEPS - 1)) begin
                    n_state = mtp_pkg::S_FIN;
                end
            end
            mtp_pkg::S_FIN: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = mtp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mtp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtp_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

@@ sv/mtp_datapath.sv @@
// mtp_datapath: character parser registers, bit-serial divider, tone ROM, output register.
// Depends on mtp_pkg; driven by mtp_ctrl commands.
`default_nettype none

module mtp_datapath #(
    parameter int MAX_NOTE_CHARS = 5
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire  [mtp_pkg::WHOLE_W-1:0]         i_cfg_wr_data,
    input  wire mtp_pkg::t_cmd                  i_cmd,
    output mtp_pkg::t_sts                       o_sts,
    input  wire                                 i_mode,
    input  wire  [7:0]                          i_char,
    input  wire  [3:0]                          i_octave,
    input  wire                                 i_last,
    input  wire                                 i_out_ready,
    output logic                                o_out_valid,
    output logic [mtp_pkg::FREQ_W-1:0]          o_freq,
    output logic [mtp_pkg::DUR_W-1:0]           o_dur,
    output mtp_pkg::t_status                    o_status
);

    // parse state
    logic [mtp_pkg::POS_W-1:0]     r_pos, n_pos;
    logic [3:0]                    r_letter, n_letter;
    mtp_pkg::t_accid               r_accid, n_accid;
    logic [mtp_pkg::DIVISOR_W-1:0] r_dacc, n_dacc;
    logic                          r_dig_end, n_dig_end;
    logic                          n_dot;
    logic                          r_bad, n_bad;
    logic                          r_rest, n_rest;
    logic [mtp_pkg::WHOLE_W-1:0]   r_whole;

    // latched at last character
    mtp_pkg::t_status              r_status, n_status;
    logic [mtp_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic                          r_dot_l;
    logic                          r_rest_l;
    logic [mtp_pkg::DIVISOR_W-1:0] r_divisor;
    logic [mtp_pkg::DIVISOR_W-1:0] r_rem;
    logic [mtp_pkg::WHOLE_W-1:0]   r_quo;

    logic                          r_out_valid;
    logic [mtp_pkg::FREQ_W-1:0]    r_out_freq;
    logic [mtp_pkg::DUR_W-1:0]     r_out_dur;
    mtp_pkg::t_status              r_out_status;

    logic                          w_is_digit;
    logic                          w_take_digit;
    logic [19:0]                   w_dprod;
    logic [3:0]                    w_oct;
    logic [mtp_pkg::IDX_W-1:0]     w_idx_raw;
    logic [mtp_pkg::IDX_W-1:0]     w_idx_adj;
    logic [2:0]                    w_letter_code;
    logic [mtp_pkg::DIVISOR_W:0]   w_trial;
    logic                          w_ge;
    logic [mtp_pkg::DIVISOR_W:0]   w_diff;
    logic [mtp_pkg::DUR_W-1:0]     w_dur;

    assign w_is_digit    = (i_char >= mtp_pkg::CH_0) && (i_char <= mtp_pkg::CH_9);
    assign w_letter_code = 3'(i_char - mtp_pkg::CH_A);
    assign w_dprod       = ({4'd0, r_dacc} << 3) + ({4'd0, r_dacc} << 1)
                         + {16'd0, i_char[3:0]};

    // next parse state for the current character
    always_comb begin
        n_pos     = r_pos;
        n_letter  = r_letter;
        n_accid   = r_accid;
        n_dacc    = r_dacc;
        n_dig_end = r_dig_end;
        n_bad     = r_bad;
        n_rest    = (r_pos == '0) ? i_mode : r_rest;
        w_take_digit = 1'b0;

        if (n_rest) begin
            w_take_digit = 1'b1;
        end else if (r_pos == '0) begin
            if (i_char >= mtp_pkg::CH_A && i_char <= mtp_pkg::CH_G) begin
                n_letter = mtp_pkg::letter_semis(w_letter_code);
            end else begin
                n_bad = 1'b1;
            end
        end else if (r_pos == mtp_pkg::POS_W'(1) && i_char == mtp_pkg::CH_SHARP) begin
            n_accid = mtp_pkg::ACC_SHARP;
        end else if (r_pos == mtp_pkg::POS_W'(1) && i_char == mtp_pkg::CH_FLAT) begin
            n_accid = mtp_pkg::ACC_FLAT;
        end else begin
            w_take_digit = 1'b1;
        end

        if (w_take_digit) begin
            if (!r_dig_end && w_is_digit) begin
                n_dacc = (w_dprod > 20'(mtp_pkg::DIVISOR_SAT)) ? mtp_pkg::DIVISOR_SAT
                                                               : w_dprod[15:0];
            end else begin
                n_dig_end = 1'b1;
            end
        end

        n_dot = (i_char == mtp_pkg::CH_DOT);
        n_pos = (r_pos == mtp_pkg::POS_MAX) ? r_pos : r_pos + 1'b1;
    end

    // result status and tone index
    always_comb begin
        w_oct     = (i_octave > mtp_pkg::OCTAVE_MAX) ? mtp_pkg::OCTAVE_MAX : i_octave;
        w_idx_raw = ({3'd0, w_oct} << 3) + ({3'd0, w_oct} << 2) + {3'd0, n_letter};
        case (n_accid)
            mtp_pkg::ACC_SHARP: w_idx_adj = w_idx_raw + 7'd2;
            mtp_pkg::ACC_FLAT:  w_idx_adj = w_idx_raw;
            default:            w_idx_adj = w_idx_raw + 7'd1;
        endcase
        n_idx = (w_idx_adj > mtp_pkg::IDX_MAX) ? mtp_pkg::IDX_MAX : w_idx_adj;

        if (!n_rest && (n_bad || n_pos > mtp_pkg::POS_W'(MAX_NOTE_CHARS))) begin
            n_status = mtp_pkg::ST_BAD_NOTE;
        end else if (n_dacc == '0) begin
            n_status = mtp_pkg::ST_NO_DIV;
        end else begin
            n_status = mtp_pkg::ST_OK;
        end
    end

    // restoring division step
    assign w_trial = {r_rem, r_quo[mtp_pkg::WHOLE_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_divisor});
    assign w_diff  = w_trial - {1'b0, r_divisor};
    assign w_dur   = {1'b0, r_quo}
                   + (r_dot_l ? {2'd0, r_quo[mtp_pkg::WHOLE_W-1:1]} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_letter    <= '0;
            r_accid     <= mtp_pkg::ACC_NATURAL;
            r_dacc      <= '0;
            r_dig_end   <= 1'b0;
            r_bad       <= 1'b0;
            r_rest      <= 1'b0;
            r_whole     <= mtp_pkg::WHOLE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_whole <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                if (i_last) begin
                    r_pos     <= '0;
                    r_letter  <= '0;
                    r_accid   <= mtp_pkg::ACC_NATURAL;
                    r_dacc    <= '0;
                    r_dig_end <= 1'b0;
                    r_bad     <= 1'b0;
                    r_rest    <= 1'b0;
                end else begin
                    r_pos     <= n_pos;
                    r_letter  <= n_letter;
                    r_accid   <= n_accid;
                    r_dacc    <= n_dacc;
                    r_dig_end <= n_dig_end;
                    r_bad     <= n_bad;
                    r_rest    <= n_rest;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_last) begin
            r_status  <= n_status;
            r_idx     <= n_idx;
            r_dot_l   <= n_dot;
            r_rest_l  <= n_rest;
            r_divisor <= n_dacc;
            r_rem     <= '0;
            r_quo     <= r_whole;
        end else if (i_cmd.step) begin
            r_rem <= w_ge ? w_diff[mtp_pkg::DIVISOR_W-1:0]
                          : w_trial[mtp_pkg::DIVISOR_W-1:0];
            r_quo <= {r_quo[mtp_pkg::WHOLE_W-2:0], w_ge};
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            if (r_status != mtp_pkg::ST_OK) begin
                r_out_freq <= '0;
                r_out_dur  <= '0;
            end else begin
                r_out_freq <= r_rest_l ? '0 : mtp_pkg::tone_rom(r_idx);
                r_out_dur  <= w_dur;
            end
        end
    end

    assign o_sts.out_full = r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_freq         = r_out_freq;
    assign o_dur          = r_out_dur;
    assign o_status       = r_out_status;

endmodule

`default_nettype wire

@@ sv/music_note_to_tone_parser.sv @@
// music_note_to_tone_parser: top level, joins mtp_ctrl and mtp_datapath to the stream ports.
// Depends on mtp_pkg, mtp_ctrl, mtp_datapath.
//
// Usage:
//  - Slave stream takes one character of a note or rest string per request.
//    tdata = {octave[11:8], symbol_char[7:0]}, tuser = mode (1 = rest string),
//    tlast marks the final character of the string.
//  - Non-final characters are taken at one per cycle while idle, with no result.
//  - The final character starts a 20-step shift/subtract divide of
//    whole_note_ms by the parsed divisor (one quotient bit per cycle), then a
//    finish cycle looks up the tone ROM and loads the output register.
//    tready stays low through the divide and the finish, so the next string's
//    characters are not taken until the result has been loaded.
//  - Master stream: tdata = {dur[34:14], freq[13:0]} zero padded to 40 bits,
//    tuser = status (0 ok, 1 invalid note, 2 zero or missing divisor).
//  - While a result waits on a stalled receiver, the next string's characters
//    and even its final character are still taken; only the finish cycle
//    waits for the output register to drain.
//  - Reset (synchronous, active low) clears the parse state, drops any result
//    and sets whole_note_ms to 2000. Write whole_note_ms only while idle.
`default_nettype none

module music_note_to_tone_parser #(
    parameter int MAX_NOTE_CHARS = 5
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // whole note length in ms
    input  wire         i_cfg_wr_en,
    input  wire  [19:0] i_cfg_wr_data,
    // character stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [7:0] symbol_char, [11:8] octave, [15:12] zero
    input  wire         s_axis_tlast,   // last_char
    input  wire  [0:0]  s_axis_tuser,   // [0] mode
    // tone stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [13:0] frequency_hz, [34:14] duration_ms, rest zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    mtp_pkg::t_cmd                    w_cmd;
    mtp_pkg::t_sts                    w_sts;
    logic [mtp_pkg::FREQ_W-1:0]       w_freq;
    logic [mtp_pkg::DUR_W-1:0]        w_dur;
    mtp_pkg::t_status                 w_status;

    mtp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mtp_datapath #(
        .MAX_NOTE_CHARS (MAX_NOTE_CHARS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_mode        (s_axis_tuser[0]),
        .i_char        (s_axis_tdata[7:0]),
        .i_octave      (s_axis_tdata[11:8]),
        .i_last        (s_axis_tlast),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_freq        (w_freq),
        .o_dur         (w_dur),
        .o_status      (w_status)
    );

    assign m_axis_tdata = {5'd0, w_dur, w_freq};
    assign m_axis_tuser = w_status;

    // final character always starts the divider, which blocks input
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken during divide");

    // a new result is only loaded from the finish cycle, when input is blocked
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared outside finish");

    // error results carry no frequency or duration
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != mtp_pkg::ST_OK) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero payload");

    // status code is never the unused value
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == mtp_pkg::ST_OK
                           || m_axis_tuser == mtp_pkg::ST_BAD_NOTE
                           || m_axis_tuser == mtp_pkg::ST_NO_DIV))
        else $error("bad status code");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// testbench: self-checking bench for music_note_to_tone_parser, with a directed table and
// random note/rest strings under several pacing and whole-note settings.
// Depends on mtp_pkg (status, accidental codes, character codes) and the parser RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT  = 4000;  // cycles with no request accepted
    localparam int SETTLE_CYC   = 30;    // extra wait after the last expected tone
    localparam int PHASE_CHARS  = 200;
    localparam int NUM_PHASES   = 5;
    localparam int MAX_NOTE_LEN = 5;

    // rounded 440*2^(n/12), B-1 .. C9
    localparam int unsigned TONE_HZ [110] = '{
        15,
        16, 17, 18, 19, 21, 22, 23, 24, 26, 28, 29, 31,
        33, 35, 37, 39, 41, 44, 46, 49, 52, 55, 58, 62,
        65, 69, 73, 78, 82, 87, 92, 98, 104, 110, 117, 123,
        131, 139, 147, 156, 165, 175, 185, 196, 208, 220, 233, 247,
        262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
        523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988,
        1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976,
        2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3951,
        4186, 4435, 4699, 4978, 5274, 5588, 5920, 6272, 6645, 7040, 7459, 7902,
        8372
    };
    // half steps above C for A..G
    localparam int unsigned NOTE_SEMIS [7] = '{9, 11, 0, 2, 4, 5, 7};

    typedef struct {
        bit       rest;     // mode: 1 rest string
        bit [7:0] symbol;
        bit [3:0] octave;
        bit       is_last;
    } char_req_t;

    typedef struct {
        bit [13:0]        freq;
        bit [20:0]        dur;
        mtp_pkg::t_status status;
    } tone_res_t;

    typedef struct {
        char_req_t req;
        bit        typed;   // expected tone written into the table
        tone_res_t res;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [19:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [7:0] symbol_char, [11:8] octave, [15:12] zero
    logic        s_axis_tlast = 1'b0;  // last_char
    logic [0:0]  s_axis_tuser = '0;    // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [13:0] frequency_hz, [34:14] duration_ms
    logic [1:0]  m_axis_tuser;         // [1:0] status

    music_note_to_tone_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // parser shadow state
    bit [19:0]       whole_ms = 20'd2000;
    bit [3:0]        pos_cnt;
    int unsigned     semis;
    mtp_pkg::t_accid accid = mtp_pkg::ACC_NATURAL;
    int unsigned     divisor;
    bit              digits_done;
    bit              dot_seen;
    bit              note_bad;
    bit              rest_str;

    tone_res_t   tone_q[$];      // expected tones, oldest first
    char_req_t   str_q[$];       // string being sent
    dir_row_t    dir_rows[$];

    int          src_gap_pct;
    int          snk_stall_pct;
    int          chars_sent;
    int          tones_seen;
    int          err_cnt;
    int          quiet_cyc;

    function automatic void clear_parse();
        pos_cnt     = '0;
        semis       = 0;
        accid       = mtp_pkg::ACC_NATURAL;
        divisor     = 0;
        digits_done = 1'b0;
        dot_seen    = 1'b0;
        note_bad    = 1'b0;
        rest_str    = 1'b0;
    endfunction

    function automatic void take_digit(input bit [7:0] c);
        int unsigned v;
        if (!digits_done && c >= mtp_pkg::CH_0 && c <= mtp_pkg::CH_9) begin
            v = divisor * 10 + (c - mtp_pkg::CH_0);
            divisor = (v > 65535) ? 65535 : v;
        end else begin
            digits_done = 1'b1;
        end
    endfunction

    // Advance the shadow parser by one character; returns 1 with the tone on the final one.
    function automatic bit parse_tone_char(input char_req_t r, output tone_res_t res);
        int unsigned oct;
        int          idx;
        int unsigned dur;
        res = '{freq: '0, dur: '0, status: mtp_pkg::ST_OK};
        if (pos_cnt == 0) rest_str = r.rest;
        if (rest_str) begin
            take_digit(r.symbol);
        end else if (pos_cnt == 0) begin
            if (r.symbol >= mtp_pkg::CH_A && r.symbol <= mtp_pkg::CH_G)
                semis = NOTE_SEMIS[r.symbol - mtp_pkg::CH_A];
            else note_bad = 1'b1;
        end else if (pos_cnt == 1 && r.symbol == mtp_pkg::CH_SHARP) begin
            accid = mtp_pkg::ACC_SHARP;
        end else if (pos_cnt == 1 && r.symbol == mtp_pkg::CH_FLAT) begin
            accid = mtp_pkg::ACC_FLAT;
        end else begin
            take_digit(r.symbol);
        end
        dot_seen = (r.symbol == mtp_pkg::CH_DOT);
        if (pos_cnt != 4'd15) pos_cnt = pos_cnt + 1'b1;
        if (!r.is_last) return 1'b0;

        // invalid note wins over a missing divisor
        if (!rest_str && (note_bad || pos_cnt > MAX_NOTE_LEN)) begin
            res.status = mtp_pkg::ST_BAD_NOTE;
        end else if (divisor == 0) begin
            res.status = mtp_pkg::ST_NO_DIV;
        end else begin
            dur = whole_ms / divisor;
            if (dot_seen) dur = dur + (dur >> 1);
            res.dur = dur[20:0];
            if (!rest_str) begin
                oct = (r.octave > 8) ? 8 : r.octave;
                idx = 12 * oct + semis + 1;
                if (accid == mtp_pkg::ACC_SHARP) idx = idx + 1;
                else if (accid == mtp_pkg::ACC_FLAT) idx = idx - 1;
                if (idx > 109) idx = 109;
                res.freq = TONE_HZ[idx][13:0];
            end
        end
        clear_parse();
        return 1'b1;
    endfunction

    function automatic void add_row(input bit rest, input byte ch, input int oct, input bit lst,
                                    input bit typed, input int f, input int d,
                                    input mtp_pkg::t_status st);
        dir_row_t row;
        row.req   = '{rest: rest, symbol: ch, octave: oct[3:0], is_last: lst};
        row.typed = typed;
        row.res   = '{freq: f[13:0], dur: d[20:0], status: st};
        dir_rows.push_back(row);
    endfunction

    function automatic void push_str_char(input bit rest, input bit [7:0] ch);
        char_req_t r;
        r.rest    = rest;
        r.symbol  = ch;
        // mostly in range, a quarter drawn from the full field, which may exceed 8
        r.octave  = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        r.is_last = 1'b0;
        str_q.push_back(r);
    endfunction

    function automatic void push_divisor(input bit rest);
        int unsigned v;
        string       s;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: v = 1 << $urandom_range(5);
            6, 7:             v = $urandom_range(1, 999);
            8:                v = $urandom_range(0, 9);
            default: begin
                if ($urandom_range(1)) return;          // divisor missing
                v = $urandom_range(60000, 999999);      // may saturate
            end
        endcase
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) push_str_char(rest, s[i]);
    endfunction

    // One string: mostly well-formed notes and rests, the rest noise.
    function automatic void build_string();
        string       noise_set;
        int          kind;
        int          n;
        bit          rest;
        noise_set = "ABCDEFGH#b.0123456789- ";
        str_q.delete();
        kind = $urandom_range(99);
        if (kind < 45) begin
            push_str_char(1'b0, 8'(mtp_pkg::CH_A + $urandom_range(6)));
            case ($urandom_range(2))
                1: push_str_char(1'($urandom_range(1)), mtp_pkg::CH_SHARP);
                2: push_str_char(1'($urandom_range(1)), mtp_pkg::CH_FLAT);
                default: ;
            endcase
            push_divisor(1'($urandom_range(1)));
            if ($urandom_range(2) == 0) push_str_char(1'($urandom_range(1)), mtp_pkg::CH_DOT);
            if ($urandom_range(9) == 0)
                push_str_char(1'($urandom_range(1)), 8'(mtp_pkg::CH_0 + $urandom_range(9)));
        end else if (kind < 70) begin
            push_divisor(1'b1);
            if ($urandom_range(2) == 0) push_str_char(1'($urandom_range(1)), mtp_pkg::CH_DOT);
        end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                rest = 1'($urandom_range(1));
                if ($urandom_range(1)) push_str_char(rest, 8'($urandom_range(255)));
                else push_str_char(rest, noise_set[$urandom_range(noise_set.len() - 1)]);
            end
        end
        if (str_q.size() == 0) push_str_char(kind >= 45, mtp_pkg::CH_DOT);
        // mode of the first character picks note or rest for well-formed kinds
        if (kind < 45) str_q[0].rest = 1'b0;
        else if (kind < 70) str_q[0].rest = 1'b1;
        str_q[str_q.size() - 1].is_last = 1'b1;
    endfunction

    // Offer one character request, with random gaps ahead of it.
    task automatic send_char(input char_req_t r, input bit typed, input tone_res_t want);
        tone_res_t pred;
        while ($urandom_range(99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, r.octave, r.symbol};
        s_axis_tlast  <= r.is_last;
        s_axis_tuser  <= r.rest;
        do @(posedge i_clk); while (!s_axis_tready);
        chars_sent++;
        if (parse_tone_char(r, pred)) tone_q.push_back(typed ? want : pred);
    endtask

    // Wait for every tone, then for any tail of work, before touching the register.
    task automatic drain();
        while (tone_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_whole_ms(input bit [19:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        whole_ms = v;
    endtask

    // Tone side: check each accepted result, then pick the next tready.
    always @(posedge i_clk) begin
        tone_res_t exp_t;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tones_seen++;
            if (tone_q.size() == 0) begin
                $error("tone result with nothing expected: tdata=%h tuser=%0d",
                       m_axis_tdata, m_axis_tuser);
                err_cnt++;
            end else begin
                exp_t = tone_q.pop_front();
                if (m_axis_tdata[13:0] != exp_t.freq) begin
                    $error("frequency_hz: expected %0d, actual %0d", exp_t.freq,
                           m_axis_tdata[13:0]);
                    err_cnt++;
                end
                if (m_axis_tdata[34:14] != exp_t.dur) begin
                    $error("duration_ms: expected %0d, actual %0d", exp_t.dur,
                           m_axis_tdata[34:14]);
                    err_cnt++;
                end
                if (m_axis_tuser != exp_t.status) begin
                    $error("status: expected %0d, actual %0d", exp_t.status, m_axis_tuser);
                    err_cnt++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Watchdog: too long without any request taken on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cyc = 0;
        end else begin
            quiet_cyc++;
            if (quiet_cyc >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        tone_res_t none;
        none = '{freq: '0, dur: '0, status: mtp_pkg::ST_OK};
        clear_parse();

        // Directed table at the reset whole note of 2000 ms
        //      rest  char  oct last typed freq  dur   status
        add_row(0,    "A",  4,  0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(0,    "4",  4,  1,   1,    440,  500,  mtp_pkg::ST_OK);
        // flat C in octave 0 wraps down to B-1
        add_row(0,    "C",  0,  0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(0,    "b",  0,  0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(0,    "1",  0,  1,   1,    15,   2000, mtp_pkg::ST_OK);
        // sharp B, octave field all ones clamps to 8, dotted
        add_row(0,    "B",  15, 0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(0,    "#",  15, 0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(0,    "1",  15, 0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(0,    ".",  15, 1,   1,    8372, 3000, mtp_pkg::ST_OK);
        // bad letter beats the zero divisor
        add_row(0,    "H",  4,  0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(0,    "0",  4,  1,   1,    0,    0,    mtp_pkg::ST_BAD_NOTE);
        // six-character note is too long
        add_row(0,    "G",  4,  0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(0,    "#",  4,  0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(0,    "1",  4,  0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(0,    "2",  4,  0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(0,    "3",  4,  0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(0,    ".",  4,  1,   1,    0,    0,    mtp_pkg::ST_BAD_NOTE);
        // rests: zero divisor, sign ends the digits, saturating divisor
        add_row(1,    "0",  0,  1,   1,    0,    0,    mtp_pkg::ST_NO_DIV);
        add_row(1,    "-",  0,  0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(1,    "4",  0,  1,   1,    0,    0,    mtp_pkg::ST_NO_DIV);
        add_row(1,    "9",  0,  0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(1,    "9",  0,  0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(1,    "9",  0,  0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(1,    "9",  0,  0,   0,    0,    0,    mtp_pkg::ST_OK);
        add_row(1,    "9",  0,  1,   1,    0,    0,    mtp_pkg::ST_OK);

        src_gap_pct   = 0;
        snk_stall_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_char(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        s_axis_tvalid <= 1'b0;

        // Random phases: whole note setting and pacing change together
        for (int p = 0; p < NUM_PHASES; p++) begin
            int phase_start;
            drain();
            case (p)
                0: begin write_whole_ms(20'hFFFFF); src_gap_pct = 0;  snk_stall_pct = 0;  end
                1: begin write_whole_ms(20'd0);     src_gap_pct = 60; snk_stall_pct = 0;  end
                2: begin
                    write_whole_ms(20'($urandom_range(1, 20'hFFFFF)));
                    src_gap_pct = 0;  snk_stall_pct = 60;
                end
                3: begin write_whole_ms(20'd2000);  src_gap_pct = 25; snk_stall_pct = 25; end
                default: begin
                    write_whole_ms(20'($urandom_range(1, 200000)));
                    src_gap_pct = 0;  snk_stall_pct = 0;
                end
            endcase
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS) begin
                build_string();
                foreach (str_q[i]) send_char(str_q[i], 1'b0, none);
            end
            s_axis_tvalid <= 1'b0;
        end

        drain();
        $display("Sent %0d characters and checked %0d tone results across %0d phases,",
                 chars_sent, tones_seen, NUM_PHASES);
        $display("with whole note at 2000, 0, max and random values under mixed pacing.");
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
